@@ design/vision_frame_receiver_unit_macros.svh @@
// assertion macros for the vision frame receiver
`ifndef VISION_FRAME_RECEIVER_UNIT_MACROS_SVH
`define VISION_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define VFR_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vfr assertion failed");

// next-cycle implication, disabled in reset
`define VFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vfr assertion failed");

`else

`define VFR_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define VFR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ design/vfr_pkg.sv @@
// shared constants and types of the vision frame receiver
`default_nettype none

package vfr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DIST_FRAC  = 16;
    localparam int FRAME_LEN  = 16;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ANG_W      = 24;
    localparam int LIM_W      = 23;
    localparam int OUT_ANG_W  = 22;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 128;
    localparam int SHIFT_BIAS = FRAC_BITS - 150;

    localparam logic [7:0] HDR_BYTE = 8'h66;
    localparam logic [7:0] TRL_BYTE = 8'h88;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT = 2'd3;

    localparam logic signed [ANG_W-1:0] ANGLE_LOW_RST   = ANG_W'(-327680);
    localparam logic signed [ANG_W-1:0] ANGLE_HIGH_RST  = ANG_W'(1638400);
    localparam logic [LIM_W-1:0]        YAW_LIMIT_RST   = LIM_W'(65536);
    localparam logic [LIM_W-1:0]        PITCH_LIMIT_RST = LIM_W'(98304);

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        logic       wr;
        logic       clr;
        logic [7:0] data;
    } store_ctl_t;

    typedef struct packed {
        logic [2:0]                   pad;
        logic                         tracking;
        logic [7:0]                   mount_mode;
        logic [15:0]                  slide_rate;
        logic [DIST_W-1:0]            range_q16;
        logic [OUT_ANG_W-1:0]         pitch_angle;
        logic [OUT_ANG_W-1:0]         yaw_angle;
        logic [15:0]                  fire_word;
        logic [7:0]                   seq_id;
    } result_t;

endpackage

`default_nettype wire

@@ design/vfr_frame_store.sv @@
// byte store and fill count of the current frame
`default_nettype none

module vfr_frame_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  vfr_pkg::store_ctl_t ctl,
    output vfr_pkg::frame_t     frame
);
    import vfr_pkg::*;

    frame_t           frame_reg, frame_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        frame_next = frame_reg;
        count_next = count_reg;
        if (ctl.clr) begin
            frame_next = '0;
            count_next = '0;
        end else if (ctl.wr && count_reg < CNT_W'(FRAME_LEN)) begin
            frame_next[count_reg[IDX_W-1:0]] = ctl.data;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            count_reg <= '0;
        end else begin
            frame_reg <= frame_next;
            count_reg <= count_next;
        end
    end

    assign frame = frame_reg;

endmodule

`default_nettype wire

@@ design/vfr_angle_update.sv @@
// float to fixed conversion, window check and step clamp of one angle
`default_nettype none

module vfr_angle_update (
    input  logic signed [vfr_pkg::ANG_W-1:0] old_angle,
    input  logic [31:0]                      float_bits,
    input  logic [vfr_pkg::LIM_W-1:0]        step_limit,
    input  logic signed [vfr_pkg::ANG_W-1:0] angle_low,
    input  logic signed [vfr_pkg::ANG_W-1:0] angle_high,
    output logic signed [vfr_pkg::ANG_W-1:0] new_angle
);
    import vfr_pkg::*;

    localparam logic signed [9:0]     SHIFT_B = 10'(SHIFT_BIAS);
    localparam logic [ANG_W-1:0]      MAG_SAT = ANG_W'(1) << (ANG_W - 1);
    localparam logic signed [ANG_W-1:0] ANG_MAX = MAG_SAT - 1'b1;

    logic                      sgn;
    logic [7:0]                ex;
    logic [22:0]               man;
    logic [23:0]               sig;
    logic signed [9:0]         sh;
    logic signed [9:0]         rs;
    logic [ANG_W-1:0]          mag;
    logic [ANG_W:0]            neg;
    logic                      is_nan;
    logic signed [ANG_W-1:0]   cand;
    logic signed [ANG_W:0]     err;
    logic signed [ANG_W:0]     lim;

    always_comb begin
        sgn    = float_bits[31];
        ex     = float_bits[30:23];
        man    = float_bits[22:0];
        sig    = {1'b1, man};
        sh     = $signed({2'b00, ex}) + SHIFT_B;
        rs     = -sh;
        is_nan = 1'b0;
        if (ex == 8'hFF) begin
            is_nan = (man != '0);
            mag    = MAG_SAT;
        end else if (ex == 8'h00) begin
            mag = '0;
        end else if (!sh[9]) begin
            mag = (sh == 10'sd0 && sig <= MAG_SAT) ? sig : MAG_SAT;
        end else if (rs >= 10'sd24) begin
            mag = '0;
        end else begin
            mag = sig >> rs[4:0];
        end

        neg = (ANG_W+1)'(0) - {1'b0, mag};
        if (sgn) begin
            cand = neg[ANG_W-1:0];
        end else begin
            cand = (mag == MAG_SAT) ? ANG_MAX : mag;
        end

        if (is_nan) begin
            cand = old_angle;
        end
        if (cand <= angle_low || cand >= angle_high) begin
            cand = old_angle;
        end

        err = {cand[ANG_W-1], cand} - {old_angle[ANG_W-1], old_angle};
        lim = $signed({2'b00, step_limit});
        if (err > lim) begin
            err = lim;
        end else if (err < -lim) begin
            err = -lim;
        end
        new_angle = old_angle + err[ANG_W-1:0];
    end

endmodule

`default_nettype wire

@@ design/vision_frame_receiver_unit.sv @@
// top level of the vision frame receiver: input register, decode, result register
//
// channel   dir  tdata                         tuser
// s_        in   [7:0] data_byte               [0] operation
// m_        out  see m_tdata port comment      none
// cfg_      in   cfg_wdata [23:0]              none (cfg_index [1:0])
//
// one transaction per cycle on the input while no idle one waits; a good idle one sets m_tvalid
// the input register and the result register are the only pipeline stages
// reset clears the frame store, the fill count, the angle and distance state and the
// handshake registers, and loads the configuration reset values
// while m_tready is low a pending result holds; byte transactions still pass,
// an idle transaction waits in the input register until the result slot frees
`default_nettype none

`include "vision_frame_receiver_unit_macros.svh"

module vision_frame_receiver_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [vfr_pkg::S_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] seq_id, [23:8] fire_word, [45:24] yaw_angle, [67:46] pitch_angle,
    // [99:68] range_q16, [115:100] slide_rate, [123:116] mount_mode,
    // [124] tracking, [127:125] zero
    output logic [vfr_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [vfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import vfr_pkg::*;

    logic                    in_valid_reg, in_valid_next;
    logic                    in_op_reg;
    logic [7:0]              in_byte_reg;

    logic signed [ANG_W-1:0] angle_low_reg, angle_high_reg;
    logic [LIM_W-1:0]        yaw_limit_reg, pitch_limit_reg;

    logic signed [ANG_W-1:0] yaw_reg, pitch_reg;
    logic [DIST_W-1:0]       dist_reg;

    logic                    m_valid_reg, m_valid_next;
    result_t                 res_reg, res_next;

    logic                    advance;
    logic                    load;
    logic                    frame_ok;
    store_ctl_t              store_ctl;
    frame_t                  frame;
    logic [15:0]             shoot;
    logic [DIST_W-1:0]       newd;
    logic [DIST_W+1:0]       dist_sum;
    logic [DIST_W-1:0]       dist_new;
    logic signed [ANG_W-1:0] yaw_new, pitch_new;

    assign advance  = in_valid_reg && (in_op_reg == OP_BYTE || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign frame_ok = (frame[0] == HDR_BYTE) && (frame[FRAME_LEN-1] == TRL_BYTE);
    assign load     = advance && in_op_reg == OP_IDLE && frame_ok;

    assign store_ctl.wr   = advance && in_op_reg == OP_BYTE;
    assign store_ctl.clr  = advance && in_op_reg == OP_IDLE;
    assign store_ctl.data = in_byte_reg;

    vfr_frame_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (store_ctl),
        .frame   (frame)
    );

    vfr_angle_update u_yaw (
        .old_angle  (yaw_reg),
        .float_bits ({frame[7], frame[6], frame[5], frame[4]}),
        .step_limit (yaw_limit_reg),
        .angle_low  (angle_low_reg),
        .angle_high (angle_high_reg),
        .new_angle  (yaw_new)
    );

    vfr_angle_update u_pitch (
        .old_angle  (pitch_reg),
        .float_bits ({frame[11], frame[10], frame[9], frame[8]}),
        .step_limit (pitch_limit_reg),
        .angle_low  (angle_low_reg),
        .angle_high (angle_high_reg),
        .new_angle  (pitch_new)
    );

    // distance smoothing: (3 * new + old) / 4
    assign shoot    = {frame[3], frame[2]};
    assign newd     = {shoot, {DIST_FRAC{1'b0}}};
    assign dist_sum = {2'b00, newd} + {1'b0, newd, 1'b0} + {2'b00, dist_reg};
    assign dist_new = dist_sum[DIST_W+1:2];

    always_comb begin
        res_next.pad         = '0;
        res_next.seq_id      = frame[1];
        res_next.fire_word   = shoot;
        res_next.yaw_angle   = yaw_new[OUT_ANG_W-1:0];
        res_next.pitch_angle = pitch_new[OUT_ANG_W-1:0];
        res_next.range_q16   = dist_new;
        res_next.slide_rate  = {frame[12], frame[13]};
        res_next.mount_mode  = frame[14];
        res_next.tracking    = (yaw_new != yaw_reg) && (pitch_new != pitch_reg)
                               && (dist_new != '0);
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            yaw_reg         <= '0;
            pitch_reg       <= '0;
            dist_reg        <= '0;
            angle_low_reg   <= ANGLE_LOW_RST;
            angle_high_reg  <= ANGLE_HIGH_RST;
            yaw_limit_reg   <= YAW_LIMIT_RST;
            pitch_limit_reg <= PITCH_LIMIT_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (load) begin
                yaw_reg   <= yaw_new;
                pitch_reg <= pitch_new;
                dist_reg  <= dist_new;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_ANGLE_LOW:   angle_low_reg   <= cfg_wdata;
                    REG_ANGLE_HIGH:  angle_high_reg  <= cfg_wdata;
                    REG_YAW_LIMIT:   yaw_limit_reg   <= cfg_wdata[LIM_W-1:0];
                    REG_PITCH_LIMIT: pitch_limit_reg <= cfg_wdata[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // an idle transaction leaves an empty store behind
    `VFR_ASSERT_NEXT(a_store_cleared, aclk, aresetn, store_ctl.clr, frame == '0)
    // a good frame always shows up as a result
    `VFR_ASSERT_NEXT(a_frame_loads, aclk, aresetn, load, m_tvalid)
    // a waiting input transaction is never dropped
    `VFR_ASSERT_NEXT(a_input_kept, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    // tracking needs a nonzero distance
    `VFR_ASSERT_IMPLY(a_track_dist, aclk, aresetn, m_tvalid && res_reg.tracking, |res_reg.range_q16)

endmodule

`default_nettype wire

@@ tb/sv/vision_frame_receiver_unit_tb.sv @@
// self-checking bench of the vision frame receiver: directed, random serial frames against a decoder model
module vision_frame_receiver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 175;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } serial_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_BYTE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ANGLE_LOW;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    vision_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    serial_item_t line_items[$];
    result_t      expected_frames[$];
    serial_item_t next_item;
    serial_item_t taken_item;
    result_t      fresh_result;
    result_t      want;
    result_t      got;
    bit           quiet = 1'b0;
    int           items_made = 0;
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    logic [7:0]   frame_bytes [FRAME_LEN];

    // decoder model state
    logic [7:0]              rx_store [FRAME_LEN] = '{default: 8'h00};
    logic [CNT_W-1:0]        rx_count = '0;
    logic signed [ANG_W-1:0] yaw_state = '0;
    logic signed [ANG_W-1:0] pitch_state = '0;
    logic [DIST_W-1:0]       dist_state = '0;
    logic signed [ANG_W-1:0] cfg_angle_low = ANGLE_LOW_RST;
    logic signed [ANG_W-1:0] cfg_angle_high = ANGLE_HIGH_RST;
    logic [LIM_W-1:0]        cfg_yaw_limit = YAW_LIMIT_RST;
    logic [LIM_W-1:0]        cfg_pitch_limit = PITCH_LIMIT_RST;

    function automatic bit angle_from_float(input logic [31:0] fbits,
                                            output logic signed [ANG_W-1:0] fix_val);
        longint mag;
        int     shift;
        logic [7:0] ex;
        ex = fbits[30:23];
        if (ex == 8'hFF) begin
            if (fbits[22:0] != '0) return 1'b0;
            mag = 64'd8388608;
        end else if (ex == 8'h00) begin
            mag = 0;
        end else begin
            shift = int'(ex) + SHIFT_BIAS;
            if (shift >= 0) begin
                mag = (shift > 23) ? 64'd8388608 : (longint'({1'b1, fbits[22:0]}) << shift);
            end else begin
                mag = (shift <= -25) ? 0 : (longint'({1'b1, fbits[22:0]}) >> (-shift));
            end
            if (mag > 8388608) mag = 8388608;
        end
        if (fbits[31]) fix_val = ANG_W'(-mag);
        else fix_val = (mag > 8388607) ? 24'sh7FFFFF : ANG_W'(mag);
        return 1'b1;
    endfunction

    function automatic logic signed [ANG_W-1:0] next_angle(input logic signed [ANG_W-1:0] old,
                                                           input logic [31:0] fbits,
                                                           input logic [LIM_W-1:0] limit);
        logic signed [ANG_W-1:0] cand;
        longint diff;
        if (!angle_from_float(fbits, cand)) cand = old;
        if (cand <= cfg_angle_low || cand >= cfg_angle_high) cand = old;
        diff = longint'(cand) - longint'(old);
        if (diff > longint'(limit)) diff = longint'(limit);
        if (diff < -longint'(limit)) diff = -longint'(limit);
        return ANG_W'(longint'(old) + diff);
    endfunction

    function automatic bit step_receiver(input serial_item_t it, output result_t res);
        logic signed [ANG_W-1:0] yaw_old;
        logic signed [ANG_W-1:0] pitch_old;
        logic [15:0]             shoot;
        logic [DIST_W-1:0]       target;
        bit                      produced;
        res = '0;
        produced = 1'b0;
        if (it.op == OP_BYTE) begin
            if (rx_count < FRAME_LEN) begin
                rx_store[rx_count[IDX_W-1:0]] = it.data;
                rx_count = rx_count + 1'b1;
            end
            return 1'b0;
        end
        if (rx_store[0] == HDR_BYTE && rx_store[15] == TRL_BYTE) begin
            yaw_old = yaw_state;
            pitch_old = pitch_state;
            shoot = {rx_store[3], rx_store[2]};
            yaw_state = next_angle(yaw_old, {rx_store[7], rx_store[6], rx_store[5], rx_store[4]},
                                   cfg_yaw_limit);
            pitch_state = next_angle(pitch_old,
                                     {rx_store[11], rx_store[10], rx_store[9], rx_store[8]},
                                     cfg_pitch_limit);
            target = DIST_W'(shoot) << DIST_FRAC;
            dist_state = DIST_W'((3 * longint'(target) + longint'(dist_state)) >> 2);
            res.seq_id = rx_store[1];
            res.fire_word = shoot;
            res.yaw_angle = yaw_state[OUT_ANG_W-1:0];
            res.pitch_angle = pitch_state[OUT_ANG_W-1:0];
            res.range_q16 = dist_state;
            res.slide_rate = {rx_store[12], rx_store[13]};
            res.mount_mode = rx_store[14];
            res.tracking = (yaw_state != yaw_old && pitch_state != pitch_old && dist_state != '0);
            produced = 1'b1;
        end
        rx_store = '{default: 8'h00};
        rx_count = '0;
        return produced;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (line_items.size() > 0 && (quiet || $urandom_range(99) >= 38)) begin
                next_item = line_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_item.op;
                s_tdata <= next_item.data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 38);
    end

    // monitor: compare results, predict from accepted transactions, track register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    got = result_t'(m_tdata);
                    check_field("seq_id", 32'(want.seq_id), 32'(got.seq_id));
                    check_field("fire_word", 32'(want.fire_word), 32'(got.fire_word));
                    check_field("yaw_angle", 32'(want.yaw_angle), 32'(got.yaw_angle));
                    check_field("pitch_angle", 32'(want.pitch_angle), 32'(got.pitch_angle));
                    check_field("range_q16", want.range_q16, got.range_q16);
                    check_field("slide_rate", 32'(want.slide_rate), 32'(got.slide_rate));
                    check_field("mount_mode", 32'(want.mount_mode), 32'(got.mount_mode));
                    check_field("tracking", 32'(want.tracking), 32'(got.tracking));
                    check_field("pad", 32'(want.pad), 32'(got.pad));
                end
            end
            if (s_tvalid && s_tready) begin
                taken_item = {s_tuser, s_tdata};
                if (step_receiver(taken_item, fresh_result)) expected_frames.push_back(fresh_result);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_ANGLE_LOW: begin
                        cfg_angle_low = cfg_wdata;
                    end
                    REG_ANGLE_HIGH: begin
                        cfg_angle_high = cfg_wdata;
                    end
                    REG_YAW_LIMIT: begin
                        cfg_yaw_limit = cfg_wdata[LIM_W-1:0];
                    end
                    REG_PITCH_LIMIT: begin
                        cfg_pitch_limit = cfg_wdata[LIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (line_items.size() == 0 && !s_tvalid && expected_frames.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void push_item(input logic op, input logic [7:0] data);
        line_items.push_back(serial_item_t'{op: op, data: data});
        items_made++;
    endfunction

    function automatic void build_frame(input logic [7:0] seq, input logic [15:0] shoot,
                                        input logic [31:0] yaw, input logic [31:0] pitch,
                                        input logic [15:0] rail, input logic [7:0] gmode);
        frame_bytes[0] = HDR_BYTE;
        frame_bytes[1] = seq;
        frame_bytes[2] = shoot[7:0];
        frame_bytes[3] = shoot[15:8];
        for (int i = 0; i < 4; i++) begin
            frame_bytes[4 + i] = yaw[8*i +: 8];
            frame_bytes[8 + i] = pitch[8*i +: 8];
        end
        frame_bytes[12] = rail[15:8];
        frame_bytes[13] = rail[7:0];
        frame_bytes[14] = gmode;
        frame_bytes[15] = TRL_BYTE;
    endfunction

    // bytes past the sixteenth are random and must be dropped
    function automatic void send_frame(input int nbytes);
        for (int i = 0; i < nbytes; i++) push_item(OP_BYTE, (i < FRAME_LEN) ? frame_bytes[i] : 8'($urandom));
        push_item(OP_IDLE, 8'($urandom));
    endfunction

    function automatic logic [31:0] rand_angle_bits();
        logic sgn;
        sgn = ($urandom_range(3) == 0);
        case ($urandom_range(11))
            0: return {sgn, 8'hFF, 23'($urandom_range(23'h7FFFFF, 1))};
            1: return {sgn, 8'hFF, 23'h0};
            2: return {sgn, 8'h00, 23'($urandom)};
            3: return $urandom;
            4: return {sgn, 8'($urandom_range(254, 135)), 23'($urandom)};
            default: return {sgn, 8'($urandom_range(136, 112)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void random_sequence();
        int r;
        int n;
        r = $urandom_range(99);
        build_frame(8'($urandom), rand_word(), rand_angle_bits(), rand_angle_bits(),
                    rand_word(), 8'($urandom));
        if (r < 70) begin
            send_frame(FRAME_LEN);
        end else if (r < 80) begin
            send_frame(FRAME_LEN + $urandom_range(5, 1));
        end else if (r < 88) begin
            case ($urandom_range(2))
                0: frame_bytes[0] = 8'($urandom_range(255, 0)) ^ 8'($urandom_range(255, 1));
                1: frame_bytes[15] = frame_bytes[15] ^ 8'($urandom_range(255, 1));
                default: begin
                end
            endcase
            send_frame($urandom_range(FRAME_LEN - 1, 1));
        end else begin
            n = $urandom_range(20);
            for (int i = 0; i < n; i++) push_item(OP_BYTE, 8'($urandom));
            push_item(OP_IDLE, 8'($urandom));
        end
    endfunction

    task automatic run_random(input int count);
        int target;
        target = items_made + count;
        while (items_made < target) random_sequence();
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (!(line_items.size() == 0 && !s_tvalid && expected_frames.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [23:0] lo, input logic [23:0] hi,
                              input logic [23:0] yaw_lim, input logic [23:0] pitch_lim);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= REG_ANGLE_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_ANGLE_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= REG_YAW_LIMIT;
        cfg_wdata <= yaw_lim;
        @(posedge aclk);
        cfg_index <= REG_PITCH_LIMIT;
        cfg_wdata <= pitch_lim;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at reset register values
        push_item(OP_IDLE, 8'hFF);
        build_frame(8'hFF, 16'hFFFF, 32'h3F800000, 32'h3FC00000, 16'h8000, 8'h00);
        send_frame(FRAME_LEN);
        build_frame(8'h00, 16'h0000, 32'h7FC00000, 32'hFF800000, 16'h7FFF, 8'hFF);
        send_frame(FRAME_LEN);
        build_frame(8'h5A, 16'h0001, 32'h7F800000, 32'h00000001, 16'hFFFF, 8'hA5);
        send_frame(FRAME_LEN);
        build_frame(8'h01, 16'h1234, 32'h41C80000, 32'hC0A00000, 16'h0000, 8'h3C);
        send_frame(FRAME_LEN);
        build_frame(8'h02, 16'h8000, 32'hC0800000, 32'h41A00000, 16'h0102, 8'h7E);
        send_frame(FRAME_LEN + 4);
        frame_bytes[0] = 8'h65;
        send_frame(FRAME_LEN);
        build_frame(8'h03, 16'h00FF, 32'h3F000000, 32'h3F000000, 16'h0001, 8'h81);
        frame_bytes[15] = 8'h89;
        send_frame(FRAME_LEN);
        send_frame(8);
        run_random(PHASE_ITEMS);
        wait_drained();

        // widest window and step, no idling on either side
        quiet = 1'b1;
        write_regs(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        build_frame(8'h10, 16'hFFFF, 32'h42C80000, 32'hC2C80000, 16'h4000, 8'h11);
        send_frame(FRAME_LEN);
        run_random(PHASE_ITEMS);
        wait_drained();
        quiet = 1'b0;

        // frozen angles
        write_regs(24'hFB0000, 24'h190000, 24'h000000, 24'h000000);
        run_random(PHASE_ITEMS);
        wait_drained();

        write_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        run_random(PHASE_ITEMS);
        wait_drained();

        write_regs(24'(-$urandom_range(40 << 16)), 24'($urandom_range(60 << 16)),
                   24'($urandom_range(4 << 16)), 24'($urandom_range(4 << 16)));
        run_random(PHASE_ITEMS);
        wait_drained();

        write_regs(ANGLE_LOW_RST, ANGLE_HIGH_RST, 24'(YAW_LIMIT_RST), 24'(PITCH_LIMIT_RST));
        run_random(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/vfr_pkg.sv
design/vfr_frame_store.sv
design/vfr_angle_update.sv
design/vision_frame_receiver_unit.sv
tb/sv/vision_frame_receiver_unit_tb.sv
